// ===== rtl/gmrf_pkg.sv =====
// ============================================================================
// gmrf_pkg: shared types and helpers for the grid move range fill block
// Holds the stage payload type and the single-step wavefront growth function.
// ============================================================================
`default_nettype none

package gmrf_pkg;

  // Cells are addressed as row * ROW_PITCH + col, whatever the grid side.
  localparam int ROW_PITCH = 8;
  localparam int CELLS     = ROW_PITCH * ROW_PITCH;
  localparam int COORD_W   = 3;
  localparam int RANGE_W   = 4;

  typedef logic [CELLS-1:0] cell_mask_t;

  // Payload carried down the wavefront pipeline.
  typedef struct packed {
    cell_mask_t         reach;
    cell_mask_t         open_cells;
    logic [RANGE_W-1:0] steps_left;
  } stage_t;

  // Mask of one column over all rows of the pitch.
  function automatic cell_mask_t column_cells(input int col);
    cell_mask_t m;
    m = '0;
    for (int r = 0; r < ROW_PITCH; r++) begin
      m[r*ROW_PITCH + col] = 1'b1;
    end
    return m;
  endfunction

  // Mask of the cells that lie inside a grid of the given side.
  function automatic cell_mask_t grid_cells(input int side);
    cell_mask_t m;
    m = '0;
    for (int r = 0; r < ROW_PITCH; r++) begin
      for (int c = 0; c < ROW_PITCH; c++) begin
        if (r < side && c < side) begin
          m[r*ROW_PITCH + c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // Four-neighbor spread of a set of cells by one step; row wrap is blocked.
  function automatic cell_mask_t grow(input cell_mask_t reach);
    cell_mask_t n;
    n = (reach >> ROW_PITCH) | (reach << ROW_PITCH);
    n = n | ((reach & ~column_cells(0)) >> 1);
    n = n | ((reach & ~column_cells(ROW_PITCH-1)) << 1);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gmrf_step.sv =====
// ============================================================================
// gmrf_step: one wavefront pipeline stage
// Grows the reached set by one step while the item still has steps left.
// ============================================================================
`default_nettype none

module gmrf_step (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire gmrf_pkg::stage_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output gmrf_pkg::stage_t     dn_data
);

  logic             valid_r;
  logic             valid_nxt;
  gmrf_pkg::stage_t data_r;
  gmrf_pkg::stage_t data_nxt;

  // The stage takes new data when it is empty or its content moves on.
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
    data_nxt  = up_data;
    if (up_data.steps_left != '0) begin
      data_nxt.reach      = up_data.reach |
                            (gmrf_pkg::grow(up_data.reach) & up_data.open_cells);
      data_nxt.steps_left = up_data.steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/grid_move_range_fill.sv =====
// ============================================================================
// grid_move_range_fill: bounded four-neighbor reach on a square grid
// Returns the mask of cells reachable from a start cell within a move range.
// ============================================================================
//
//  Channel  Direction  Payload (lowest bit up)
//  in_*     input      passable_map[63:0], start_row[66:64], start_col[69:67],
//                      move_range[73:70], zero fill [79:74]
//  out_*    output     reach_mask[63:0]
//
// An accepted transaction lands in the entry register and then passes the
// chain of MAX_RANGE wavefront stages, one step each; the last stage register
// is the result register. One transaction can be accepted in every cycle
// while the output is not stalled.
// Every stage has its own valid bit and a local ready, so bubbles are
// squeezed out and a stalled output holds the whole chain without loss.
// Reset (rst_n low, synchronous) clears only the valid bits.
// Cells outside a grid smaller than eight on a side are never marked, and a
// start row or column beyond the grid saturates to its last row or column.
// ============================================================================
`default_nettype none

module grid_move_range_fill #(
  parameter int GRID_SIDE = 8,
  parameter int MAX_RANGE = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // passable_map[63:0], start_row[66:64], start_col[69:67], move_range[73:70]
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // reach_mask[63:0]
  output logic [63:0]      out_tdata
);

  localparam gmrf_pkg::cell_mask_t GRID_MASK = gmrf_pkg::grid_cells(GRID_SIDE);
  localparam logic [gmrf_pkg::COORD_W-1:0] SIDE_LAST =
    gmrf_pkg::COORD_W'(GRID_SIDE - 1);

  // Unpacked input fields.
  gmrf_pkg::cell_mask_t               in_map;
  logic [gmrf_pkg::COORD_W-1:0]       in_row;
  logic [gmrf_pkg::COORD_W-1:0]       in_col;
  logic [gmrf_pkg::RANGE_W-1:0]       in_range;

  assign in_map   = in_tdata[63:0];
  assign in_row   = in_tdata[66:64];
  assign in_col   = in_tdata[69:67];
  assign in_range = in_tdata[73:70];

  // Entry stage: saturate the start and range, seed the one-hot start cell.
  logic [gmrf_pkg::COORD_W-1:0] row_sat;
  logic [gmrf_pkg::COORD_W-1:0] col_sat;
  gmrf_pkg::stage_t             ent_nxt;
  gmrf_pkg::stage_t             ent_r;
  logic                         ent_v_r;
  logic                         ent_v_nxt;
  logic                         ent_dn_ready;

  always_comb begin
    row_sat = (in_row > SIDE_LAST) ? SIDE_LAST : in_row;
    col_sat = (in_col > SIDE_LAST) ? SIDE_LAST : in_col;
    ent_nxt.reach      = gmrf_pkg::cell_mask_t'(1) << {row_sat, col_sat};
    ent_nxt.open_cells = in_map & GRID_MASK;
    if (int'(in_range) > MAX_RANGE) begin
      ent_nxt.steps_left = gmrf_pkg::RANGE_W'(MAX_RANGE);
    end else begin
      ent_nxt.steps_left = in_range;
    end
  end

  assign in_tready = !ent_v_r || ent_dn_ready;
  assign ent_v_nxt = in_tready ? in_tvalid : ent_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else begin
      ent_v_r <= ent_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ent_r <= ent_nxt;
    end
  end

  // Wavefront chain: element 0 is the entry stage, element i the i-th step.
  logic             chain_v   [MAX_RANGE+1];
  logic             chain_rdy [MAX_RANGE+1];
  gmrf_pkg::stage_t chain_d   [MAX_RANGE+1];

  assign chain_v[0]   = ent_v_r;
  assign chain_d[0]   = ent_r;
  assign ent_dn_ready = chain_rdy[0];

  for (genvar i = 0; i < MAX_RANGE; i++) begin : g_step
    gmrf_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_v[i]),
      .up_ready (chain_rdy[i]),
      .up_data  (chain_d[i]),
      .dn_valid (chain_v[i+1]),
      .dn_ready (chain_rdy[i+1]),
      .dn_data  (chain_d[i+1])
    );
  end

  // The last stage register is the output register.
  assign chain_rdy[MAX_RANGE] = out_tready;
  assign out_tvalid           = chain_v[MAX_RANGE];
  assign out_tdata            = chain_d[MAX_RANGE].reach;

  // A finished result has used up its whole step budget.
  a_steps_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chain_d[MAX_RANGE].steps_left == '0)
    else $error("result leaves the chain with steps left");

  // No cell outside the grid is ever marked.
  a_in_grid : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata & ~GRID_MASK) == '0)
    else $error("reach mask marks a cell outside the grid");

  // An accepted transaction always lands in the entry stage.
  a_entry_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ent_v_r)
    else $error("accepted transaction lost at entry");

  // The reached set always holds exactly one seed or more cells.
  a_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != '0)
    else $error("empty reach mask");

endmodule

`default_nettype wire
